### sv/mp3fs_pkg.sv
package mp3fs_pkg;

  // Width of the running byte offset counter
  localparam int OFFSET_BITS = 32;

  localparam logic [1:0] KIND_TAG    = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_AUDIO  = 2'd2;

  localparam logic [1:0] RATE_44K    = 2'd0;
  localparam logic [1:0] RATE_48K    = 2'd1;
  localparam logic [1:0] RATE_32K    = 2'd2;
  localparam logic [1:0] RATE_RSVD   = 2'd3;

  localparam int LEN_BITS = 11;

  // round(144 * kbps * 1000 / rate) for each bitrate index; free and bad index give 0
  localparam logic [LEN_BITS-1:0] LEN_44K [16] = '{
    11'd0,   11'd104, 11'd131, 11'd157, 11'd183, 11'd209, 11'd261, 11'd313,
    11'd366, 11'd418, 11'd522, 11'd627, 11'd731, 11'd836, 11'd1045, 11'd0
  };
  localparam logic [LEN_BITS-1:0] LEN_48K [16] = '{
    11'd0,   11'd96,  11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
    11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0
  };
  localparam logic [LEN_BITS-1:0] LEN_32K [16] = '{
    11'd0,   11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
    11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] start_offset;
    logic [31:0] item_length;
    logic [31:0] frame_id;
    logic [3:0]  bitrate_index;
    logic [1:0]  rate_index;
    logic        padding_bit;
  } result_t;

  // Frame length without padding; 0 for the reserved rate
  function automatic logic [LEN_BITS-1:0] base_length(input logic [3:0] bri,
                                                      input logic [1:0] sri);
    logic [LEN_BITS-1:0] len;
    len = '0;
    unique case (sri)
      RATE_44K: len = LEN_44K[bri];
      RATE_48K: len = LEN_48K[bri];
      RATE_32K: len = LEN_32K[bri];
      default:  len = '0;
    endcase
    return len;
  endfunction

endpackage

### sv/mp3fs_in_stage.sv
module mp3fs_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 advance,
  output logic                 item_valid,
  output mp3fs_pkg::in_item_t  item
);

  logic                valid;
  mp3fs_pkg::in_item_t hold;

  // Stall only while a byte is held and the scanner cannot take it
  assign in_stall   = valid && !advance;
  assign item_valid = valid;
  assign item       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold.data_byte <= data_byte;
      hold.last_byte <= last_byte;
    end
  end

endmodule

### sv/mp3fs_core.sv
module mp3fs_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  mp3fs_pkg::in_item_t  item,
  output logic                 res_valid,
  output mp3fs_pkg::result_t   res
);

  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_FRAMES = 2'd1;
  localparam logic [1:0] PH_AUDIO  = 2'd2;

  localparam int OB = mp3fs_pkg::OFFSET_BITS;

  logic [1:0]    phase, phase_next;
  logic [OB-1:0] byte_offset;
  logic [31:0]   tag_end, tag_end_next;
  logic [7:0]    header_bytes [10];
  logic [3:0]    header_count, header_count_next;
  logic [31:0]   skip_count, skip_count_next;
  logic [15:0]   sync_window, sync_window_next;
  logic [1:0]    window_fill, window_fill_next;

  // Effective state after the tag-end switch into audio
  logic [1:0]    ph_e;
  logic [3:0]    hc_e;
  logic [31:0]   skip_e;
  logic [15:0]   win_e;
  logic [1:0]    fill_e;
  logic          store_en;

  logic [7:0]    b;
  logic [27:0]   tag_size;
  logic [31:0]   fr_id;
  logic [31:0]   fr_size;
  logic [1:0]    fill_inc;
  logic [3:0]    bri;
  logic [1:0]    sri;
  logic          pad;
  logic          sync_hit;
  logic [mp3fs_pkg::LEN_BITS-1:0] alen;

  assign b = item.data_byte;

  assign tag_size = {header_bytes[6][6:0], header_bytes[7][6:0],
                     header_bytes[8][6:0], b[6:0]};
  assign fr_id    = {header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]};
  assign fr_size  = {header_bytes[4], header_bytes[5], header_bytes[6], header_bytes[7]};

  assign bri      = b[7:4];
  assign sri      = b[3:2];
  assign pad      = b[1];
  assign sync_hit = (win_e[15:8] == 8'hFF) && ((win_e[7:0] & 8'hE0) == 8'hE0);

  always_comb begin
    ph_e   = phase;
    hc_e   = header_count;
    skip_e = skip_count;
    win_e  = sync_window;
    fill_e = window_fill;
    if (phase == PH_FRAMES && byte_offset == OB'(tag_end)) begin
      ph_e   = PH_AUDIO;
      hc_e   = '0;
      skip_e = '0;
      win_e  = '0;
      fill_e = '0;
    end
  end

  always_comb begin
    alen = '0;
    if (sync_hit && sri != mp3fs_pkg::RATE_RSVD) begin
      alen = mp3fs_pkg::base_length(bri, sri) + mp3fs_pkg::LEN_BITS'(pad);
    end
  end

  always_comb begin
    phase_next        = ph_e;
    tag_end_next      = tag_end;
    header_count_next = hc_e;
    skip_count_next   = skip_e;
    sync_window_next  = win_e;
    window_fill_next  = fill_e;
    store_en          = 1'b0;
    fill_inc          = (fill_e < 2'd3) ? fill_e + 2'd1 : 2'd3;
    res_valid         = 1'b0;
    res               = '0;

    unique case (ph_e)
      PH_TAG: begin
        store_en          = 1'b1;
        header_count_next = hc_e + 4'd1;
        if (hc_e == 4'd9) begin
          tag_end_next         = 32'd10 + {4'd0, tag_size};
          res_valid            = 1'b1;
          res.item_kind        = mp3fs_pkg::KIND_TAG;
          res.start_offset     = 32'(byte_offset - OB'(9));
          res.item_length      = {4'd0, tag_size};
          header_count_next    = '0;
          skip_count_next      = '0;
          phase_next           = PH_FRAMES;
        end
      end
      PH_FRAMES: begin
        if (skip_e != '0) begin
          skip_count_next = skip_e - 32'd1;
        end else begin
          store_en          = 1'b1;
          header_count_next = hc_e + 4'd1;
          if (hc_e == 4'd9) begin
            header_count_next = '0;
            if (fr_id == '0) begin
              // run out the rest of the tag
              skip_count_next = '1;
            end else begin
              res_valid        = 1'b1;
              res.item_kind    = mp3fs_pkg::KIND_FRAME;
              res.start_offset = 32'(byte_offset - OB'(9));
              res.item_length  = (fr_size > 32'hFFFF_FFF5) ? '1 : fr_size + 32'd10;
              res.frame_id     = fr_id;
              skip_count_next  = fr_size;
            end
          end
        end
      end
      PH_AUDIO: begin
        if (skip_e != '0) begin
          skip_count_next = skip_e - 32'd1;
        end else begin
          sync_window_next = {win_e[7:0], b};
          window_fill_next = fill_inc;
          if (fill_inc == 2'd3) begin
            if (alen != '0) begin
              res_valid         = 1'b1;
              res.item_kind     = mp3fs_pkg::KIND_AUDIO;
              res.start_offset  = 32'(byte_offset - OB'(2));
              res.item_length   = 32'(alen);
              res.bitrate_index = bri;
              res.rate_index    = sri;
              res.padding_bit   = pad;
              if (alen >= mp3fs_pkg::LEN_BITS'(3)) begin
                skip_count_next  = 32'(alen - mp3fs_pkg::LEN_BITS'(3));
                window_fill_next = '0;
              end else begin
                window_fill_next = 2'(mp3fs_pkg::LEN_BITS'(3) - alen);
              end
            end else begin
              // slide one byte
              window_fill_next = 2'd2;
            end
          end
        end
      end
      default: begin
        phase_next = PH_TAG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TAG;
      byte_offset  <= '0;
      tag_end      <= '0;
      header_count <= '0;
      skip_count   <= '0;
      sync_window  <= '0;
      window_fill  <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        phase        <= PH_TAG;
        byte_offset  <= '0;
        tag_end      <= '0;
        header_count <= '0;
        skip_count   <= '0;
        sync_window  <= '0;
        window_fill  <= '0;
      end else begin
        phase        <= phase_next;
        byte_offset  <= byte_offset + OB'(1);
        tag_end      <= tag_end_next;
        header_count <= header_count_next;
        skip_count   <= skip_count_next;
        sync_window  <= sync_window_next;
        window_fill  <= window_fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_en) begin
      header_bytes[hc_e] <= b;
    end
  end

endmodule

### sv/mp3fs_out_stage.sv
module mp3fs_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                res_valid,
  input  mp3fs_pkg::result_t  res,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output mp3fs_pkg::result_t  out_res
);

  logic               valid;
  mp3fs_pkg::result_t hold;

  // Free when empty or when the held transaction leaves this cycle
  assign advance   = !valid || !out_stall;
  assign out_valid = valid;
  assign out_res   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      hold <= res;
    end
  end

endmodule

### sv/mp3_stream_frame_scanner.sv
// Byte-serial MP3 file scanner: ID3v2 tag header, tag frame headers, then
// MPEG-1 Layer III audio frame headers.
// Input channel: one file byte per transaction on data_byte, with last_byte
// high on the final byte of the file; the scanner then restarts for a new file.
// Output channel: at most one report per input byte, item_kind selecting
// tag header, tag frame header or audio frame header; unused fields read 0.
// Path: a byte goes into the input register, is processed by the core once the
// result register is free, and its report is held in the result register for the
// receiver (input register, then result register).
// Throughput: one byte per cycle unless out_stall holds a report; the state
// update is a single pass of short logic plus a constant frame-length table lookup.
// Reset: both stages empty, offset cleared, scanner waits for a tag header.
// Stall: a held report stays on the outputs while out_stall is high; at most
// one more byte is taken into the input register, then in_stall rises until
// the report is taken.
module mp3_stream_frame_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  item_kind,
  output logic [31:0] start_offset,
  output logic [31:0] item_length,
  output logic [31:0] frame_id,
  output logic [3:0]  bitrate_index,
  output logic [1:0]  rate_index,
  output logic        padding_bit
);

  logic                advance;
  logic                item_valid;
  logic                fire;
  logic                res_valid;
  mp3fs_pkg::in_item_t item;
  mp3fs_pkg::result_t  res;
  mp3fs_pkg::result_t  out_res;

  assign fire = item_valid && advance;

  mp3fs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mp3fs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mp3fs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign item_kind     = out_res.item_kind;
  assign start_offset  = out_res.start_offset;
  assign item_length   = out_res.item_length;
  assign frame_id      = out_res.frame_id;
  assign bitrate_index = out_res.bitrate_index;
  assign rate_index    = out_res.rate_index;
  assign padding_bit   = out_res.padding_bit;

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_audio_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == mp3fs_pkg::KIND_AUDIO) |-> (item_length != '0))
    else $error("audio frame reported with zero length");

  a_id_only_on_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind != mp3fs_pkg::KIND_FRAME) |-> (frame_id == '0))
    else $error("frame id set on a non tag-frame report");

  a_stall_holds_core: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !fire)
    else $error("scanner advanced while result register was blocked");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DIR_ROWS   = 33;
  localparam int RAND_ITEMS = 1150;

  localparam int unsigned KBPS [16] = '{
    0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0
  };
  localparam int unsigned HZ [4] = '{44100, 48000, 32000, 0};

  typedef enum logic [1:0] {PH_TAG_HDR, PH_TAG_FRAMES, PH_AUDIO} scan_phase_e;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_e;

  // One input byte; typed rows carry a report written in by hand
  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic               typed;
    mp3fs_pkg::result_t want;
  } byte_row_t;

  localparam mp3fs_pkg::result_t TAG_MAX = '{item_kind: mp3fs_pkg::KIND_TAG,
    start_offset: 32'd0, item_length: 32'h0FFF_FFFF, frame_id: 32'd0,
    bitrate_index: 4'd0, rate_index: 2'd0, padding_bit: 1'b0};
  localparam mp3fs_pkg::result_t FRAME_MAX = '{item_kind: mp3fs_pkg::KIND_FRAME,
    start_offset: 32'd10, item_length: 32'hFFFF_FFFF, frame_id: 32'hFFFF_FFFF,
    bitrate_index: 4'd0, rate_index: 2'd0, padding_bit: 1'b0};
  localparam mp3fs_pkg::result_t TAG_EMPTY = '{item_kind: mp3fs_pkg::KIND_TAG,
    start_offset: 32'd0, item_length: 32'd0, frame_id: 32'd0, bitrate_index: 4'd0,
    rate_index: 2'd0, padding_bit: 1'b0};
  localparam mp3fs_pkg::result_t AUDIO_MAX = '{item_kind: mp3fs_pkg::KIND_AUDIO,
    start_offset: 32'd10, item_length: 32'd1441, frame_id: 32'd0, bitrate_index: 4'd14,
    rate_index: mp3fs_pkg::RATE_32K, padding_bit: 1'b1};

  // File 1: largest tag size, then a frame header of all ones (size saturates).
  // File 2: empty tag, audio starts at offset 10 with the longest frame.
  localparam byte_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h49, 1'b0, 1'b0, '0}, '{8'h44, 1'b0, 1'b0, '0}, '{8'h33, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, TAG_MAX},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, FRAME_MAX},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, TAG_EMPTY},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hEB, 1'b1, 1'b1, AUDIO_MAX}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  item_kind;
  logic [31:0] start_offset;
  logic [31:0] item_length;
  logic [31:0] frame_id;
  logic [3:0]  bitrate_index;
  logic [1:0]  rate_index;
  logic        padding_bit;

  mp3_stream_frame_scanner u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .item_kind     (item_kind),
    .start_offset  (start_offset),
    .item_length   (item_length),
    .frame_id      (frame_id),
    .bitrate_index (bitrate_index),
    .rate_index    (rate_index),
    .padding_bit   (padding_bit)
  );

  always #5 clk = ~clk;

  byte_row_t          file_bytes [$];
  mp3fs_pkg::result_t pending_reports [$];
  int                 acc_idx = 0;
  int                 files_seen = 0;
  int                 mismatches = 0;
  int                 kind_seen [3] = '{0, 0, 0};

  // Scanner state as the stream should leave it
  scan_phase_e p_phase;
  logic [31:0] p_offset;
  logic [31:0] p_tag_end;
  logic [7:0]  p_hdr [10];
  int          p_hdr_cnt;
  logic [31:0] p_skip;
  logic [23:0] p_window;
  int          p_fill;

  mp3fs_pkg::result_t pred_rep;
  bit                 pred_hit;
  byte_row_t          cur_row;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic int unsigned frame_len(input logic [3:0] bri, input logic [1:0] sri,
                                            input logic pad);
    int unsigned hz;
    hz = HZ[sri];
    if (hz == 0) return 0;
    return (144 * KBPS[bri] * 1000 + hz / 2) / hz + pad;
  endfunction

  function automatic mp3fs_pkg::result_t mk_result(input logic [1:0] kind,
                                                   input logic [31:0] start,
                                                   input logic [31:0] len,
                                                   input logic [31:0] id,
                                                   input logic [3:0] bri,
                                                   input logic [1:0] sri,
                                                   input logic pad);
    mp3fs_pkg::result_t r;
    r.item_kind     = kind;
    r.start_offset  = start;
    r.item_length   = len;
    r.frame_id      = id;
    r.bitrate_index = bri;
    r.rate_index    = sri;
    r.padding_bit   = pad;
    return r;
  endfunction

  function automatic void scan_reset();
    p_phase   = PH_TAG_HDR;
    p_offset  = '0;
    p_tag_end = '0;
    foreach (p_hdr[i]) p_hdr[i] = '0;
    p_hdr_cnt = 0;
    p_skip    = '0;
    p_window  = '0;
    p_fill    = 0;
  endfunction

  // Advance the scanner state by one byte; return 1 when a report comes out
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output mp3fs_pkg::result_t r);
    logic [31:0] pos;
    logic [31:0] size;
    logic [31:0] id;
    logic [31:0] total;
    int unsigned len;
    logic [7:0]  w0;
    logic [7:0]  w1;
    logic [7:0]  w2;
    bit          hit;
    hit = 1'b0;
    r   = '0;
    pos = p_offset;
    if (p_phase == PH_TAG_FRAMES && pos == p_tag_end) begin
      p_phase   = PH_AUDIO;
      p_skip    = '0;
      p_hdr_cnt = 0;
      p_window  = '0;
      p_fill    = 0;
    end
    case (p_phase)
      PH_TAG_HDR: begin
        p_hdr[p_hdr_cnt] = b;
        p_hdr_cnt++;
        if (p_hdr_cnt == 10) begin
          size = {4'd0, p_hdr[6][6:0], p_hdr[7][6:0], p_hdr[8][6:0], p_hdr[9][6:0]};
          p_tag_end = size + 32'd10;
          r = mk_result(mp3fs_pkg::KIND_TAG, pos - 32'd9, size, 32'd0, 4'd0, 2'd0, 1'b0);
          hit = 1'b1;
          p_hdr_cnt = 0;
          p_skip = '0;
          p_phase = PH_TAG_FRAMES;
        end
      end
      PH_TAG_FRAMES: begin
        if (p_skip != 0) begin
          p_skip--;
        end else begin
          p_hdr[p_hdr_cnt] = b;
          p_hdr_cnt++;
          if (p_hdr_cnt == 10) begin
            id   = {p_hdr[3], p_hdr[2], p_hdr[1], p_hdr[0]};
            size = {p_hdr[4], p_hdr[5], p_hdr[6], p_hdr[7]};
            p_hdr_cnt = 0;
            if (id == 0) begin
              // zero id: idle until the tag end
              p_skip = '1;
            end else begin
              total = (size > 32'hFFFF_FFF5) ? 32'hFFFF_FFFF : size + 32'd10;
              r = mk_result(mp3fs_pkg::KIND_FRAME, pos - 32'd9, total, id, 4'd0, 2'd0,
                            1'b0);
              hit = 1'b1;
              p_skip = size;
            end
          end
        end
      end
      default: begin
        if (p_skip != 0) begin
          p_skip--;
        end else begin
          p_window = {p_window[15:0], b};
          if (p_fill < 3) p_fill++;
          if (p_fill == 3) begin
            w0 = p_window[23:16];
            w1 = p_window[15:8];
            w2 = p_window[7:0];
            len = (w0 == 8'hFF && w1[7:5] == 3'b111) ? frame_len(w2[7:4], w2[3:2], w2[1]) : 0;
            if (len != 0) begin
              r = mk_result(mp3fs_pkg::KIND_AUDIO, pos - 32'd2, len, 32'd0, w2[7:4],
                            w2[3:2], w2[1]);
              hit = 1'b1;
              if (len >= 3) begin
                p_skip = len - 3;
                p_fill = 0;
              end else begin
                p_fill = 3 - int'(len);
              end
            end else begin
              p_fill = 2;
            end
          end
        end
      end
    endcase
    p_offset = pos + 32'd1;
    if (last) scan_reset();
    return hit;
  endfunction

  // Append one file: tag header, tag frames, then (for a tag of at most 80 bytes) audio headers, possibly cut short
  task automatic add_random_file();
    logic [7:0]  fb [$];
    byte_row_t   row;
    int          tag_size;
    int          room;
    int          base;
    int          nfr;
    int          cut;
    int          f;
    int          k;
    int          j;
    int unsigned pick;
    int unsigned flen;
    logic [31:0] fsz;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        pad;
    pick = $urandom_range(0, 99);
    if (pick < 15) tag_size = 0;
    else if (pick < 85) tag_size = $urandom_range(1, 60);
    else tag_size = $urandom_range(0, 32'h0FFF_FFFF);
    if ($urandom_range(0, 3) == 0) begin
      repeat (6) fb.push_back(rand_byte());
    end else begin
      fb.push_back(8'h49);
      fb.push_back(8'h44);
      fb.push_back(8'h33);
      fb.push_back(8'($urandom_range(2, 4)));
      fb.push_back(8'h00);
      fb.push_back(rand_byte());
    end
    // syncsafe size; the top bit of each byte is noise
    for (k = 3; k >= 0; k--) fb.push_back({1'($urandom_range(0, 3) == 0), 7'(tag_size >> (7 * k))});

    room = (tag_size > 80) ? 80 : tag_size;
    base = fb.size();
    while (fb.size() - base < room) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat (4) fb.push_back(8'h00);
      end else if (pick < 80) begin
        repeat (4) fb.push_back(8'($urandom_range(8'h30, 8'h5A)));
      end else begin
        repeat (4) fb.push_back(rand_byte());
      end
      pick = $urandom_range(0, 99);
      fsz = (pick < 85) ? $urandom_range(0, 12) : (pick < 95) ? $urandom_range(0, 40) : $urandom;
      fb.push_back(fsz[31:24]);
      fb.push_back(fsz[23:16]);
      fb.push_back(fsz[15:8]);
      fb.push_back(fsz[7:0]);
      fb.push_back(rand_byte());
      fb.push_back(rand_byte());
      for (j = 0; j < fsz && (fb.size() - base) < room; j++) fb.push_back(rand_byte());
    end
    // trim so the last frame header may cross the tag end
    while (fb.size() - base > room) void'(fb.pop_back());

    if (tag_size <= 80) begin
      nfr = $urandom_range(1, 5);
      for (f = 0; f < nfr; f++) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) fb.push_back(rand_byte());
        b0  = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'hFF;
        b1  = ($urandom_range(0, 4) == 0) ? rand_byte() : {3'b111, 5'($urandom)};
        bri = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 0) ? 4'd0 : 4'd15)
                                          : 4'($urandom_range(1, 14));
        sri = ($urandom_range(0, 9) == 0) ? mp3fs_pkg::RATE_RSVD : 2'($urandom_range(0, 2));
        pad = 1'($urandom);
        fb.push_back(b0);
        fb.push_back(b1);
        fb.push_back({bri, sri, pad, 1'($urandom)});
        flen = (b0 == 8'hFF && b1[7:5] == 3'b111) ? frame_len(bri, sri, pad) : 0;
        if (flen >= 3) begin
          if (flen <= 260 && $urandom_range(0, 3) == 0) begin
            repeat (flen - 3) fb.push_back(rand_byte());
          end else begin
            // end the file inside the frame body
            repeat ($urandom_range(0, 6)) fb.push_back(rand_byte());
            break;
          end
        end
      end
    end

    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, fb.size());
      while (fb.size() > cut) void'(fb.pop_back());
    end
    for (k = 0; k < fb.size(); k++) begin
      row.data  = fb[k];
      row.last  = (k == fb.size() - 1);
      row.typed = 1'b0;
      row.want  = '0;
      file_bytes.push_back(row);
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_report();
    mp3fs_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      note_mismatch($sformatf("unexpected report kind %0d at offset %0d", item_kind,
                              start_offset));
      return;
    end
    want = pending_reports.pop_front();
    cmp_field("item_kind", 32'(item_kind), 32'(want.item_kind));
    cmp_field("start_offset", start_offset, want.start_offset);
    cmp_field("item_length", item_length, want.item_length);
    cmp_field("frame_id", frame_id, want.frame_id);
    cmp_field("bitrate_index", 32'(bitrate_index), 32'(want.bitrate_index));
    cmp_field("rate_index", 32'(rate_index), 32'(want.rate_index));
    cmp_field("padding_bit", 32'(padding_bit), 32'(want.padding_bit));
    if (item_kind <= mp3fs_pkg::KIND_AUDIO) kind_seen[item_kind]++;
  endtask

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pred_hit = scan_byte(data_byte, last_byte, pred_rep);
      cur_row = file_bytes[acc_idx];
      if (cur_row.typed) pending_reports.push_back(cur_row.want);
      else if (pred_hit) pending_reports.push_back(pred_rep);
      if (last_byte) files_seen++;
      acc_idx++;
    end
    if (!rst && out_valid && !out_stall) check_report();
  end

  // Receiver back-pressure: switch between patterns every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
      STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
      default:      out_stall <= ((stall_tick % 32) >= 12);
    endcase
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    int drv_idx;
    int burst;
    int gap;
    int k;
    scan_reset();
    for (k = 0; k < DIR_ROWS; k++) file_bytes.push_back(DIR_TAB[k]);
    while (file_bytes.size() < DIR_ROWS + RAND_ITEMS) add_random_file();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drv_idx = 0;
    while (drv_idx < file_bytes.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      for (k = 0; k < burst && drv_idx < file_bytes.size(); k++) begin
        data_byte <= file_bytes[drv_idx].data;
        last_byte <= file_bytes[drv_idx].last;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        drv_idx++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
      // hold valid high across a zero gap
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (acc_idx < file_bytes.size()) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: fed %0d bytes over %0d files, %0d mismatches", acc_idx, files_seen,
             mismatches);
    $display("tb: reports checked: %0d tag headers, %0d tag frames, %0d audio frames",
             kind_seen[0], kind_seen[1], kind_seen[2]);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
